@@ design/config_language_tokenizer_assert.svh @@
// Assertion macros shared by the tokenizer checker.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef CONFIG_LANGUAGE_TOKENIZER_ASSERT_SVH
`define CONFIG_LANGUAGE_TOKENIZER_ASSERT_SVH

// Implication in the same cycle, ignored while reset is high.
`define CLTOK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// Implication into the next cycle, checked during reset as well.
`define CLTOK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

@@ design/cltok_pkg.sv @@
// Types, constants and keyword tables for the configuration language tokenizer.
// No dependencies; every other design file but the assertion header imports this package.
package cltok_pkg;

  localparam int OFFSET_WIDTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT  = 4;
  localparam int TOK_W                = 16;

  typedef enum logic [3:0] {
    KIND_END     = 4'd0,
    KIND_LPAREN  = 4'd1,
    KIND_RPAREN  = 4'd2,
    KIND_LBRACE  = 4'd3,
    KIND_RBRACE  = 4'd4,
    KIND_PIPE    = 4'd5,
    KIND_STRING  = 4'd6,
    KIND_SYMBOL  = 4'd7,
    KIND_KEYWORD = 4'd8,
    KIND_INVALID = 4'd9
  } cltok_kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_SYMBOL = 2'd2
  } cltok_mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } cltok_in_t;

  typedef struct packed {
    logic [3:0]       token_kind;
    logic [TOK_W-1:0] token_start;
    logic [TOK_W-1:0] token_length;
    logic             run_end;
  } cltok_out_t;

  typedef struct packed {
    cltok_kind_t      kind;
    logic [TOK_W-1:0] start;
    logic [TOK_W-1:0] length;
  } cltok_tok_t;

  // All tokens caused by one input item, oldest in slot 0.
  typedef struct packed {
    cltok_tok_t [2:0] tok;
    logic [1:0]       cnt;
  } cltok_group_t;

  // Keywords: bit 0 setup, bit 1 provides, bit 2 command.
  localparam logic [7:0] KW_TEXT [3][8] = '{
    '{8'h73, 8'h65, 8'h74, 8'h75, 8'h70, 8'h00, 8'h00, 8'h00},
    '{8'h70, 8'h72, 8'h6f, 8'h76, 8'h69, 8'h64, 8'h65, 8'h73},
    '{8'h63, 8'h6f, 8'h6d, 8'h6d, 8'h61, 8'h6e, 8'h64, 8'h00}
  };
  localparam logic [3:0] KW_LEN [3] = '{4'd5, 4'd8, 4'd7};

  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0d;

endpackage

@@ design/cltok_front.sv @@
// Scanner front end: classifies each byte, tracks the open token and builds
// the group of tokens the byte causes. Depends on cltok_pkg.
module cltok_front import cltok_pkg::*; #(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  cltok_in_t    item,
  output logic         grp_valid,
  output cltok_group_t grp
);

  localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = '1;

  cltok_mode_t             mode, mode_next, mode_step;
  logic [OFFSET_WIDTH-1:0] pos, pos_next;
  logic [OFFSET_WIDTH-1:0] start, start_next, start_step;
  logic [OFFSET_WIDTH-1:0] len, len_next, len_step;
  logic [2:0]              match, match_next, match_step;

  logic        is_blank, is_letter, is_quote, is_nl;
  cltok_kind_t single_kind;
  logic        taken, close_v, byte_v, flush_v;
  cltok_tok_t  close_tok, byte_tok, flush_tok, end_tok;

  function automatic logic [OFFSET_WIDTH-1:0] sat_inc(input logic [OFFSET_WIDTH-1:0] v);
    return (v == OFS_MAX) ? v : v + 1'b1;
  endfunction

  // Drops the keywords whose letter at index i differs from c.
  function automatic logic [2:0] match_at(input logic [2:0] m,
                                          input logic [OFFSET_WIDTH-1:0] i,
                                          input logic [7:0] c);
    logic [2:0] r;
    r = m;
    for (int k = 0; k < 3; k++) begin
      if (i >= OFFSET_WIDTH'(KW_LEN[k]) || KW_TEXT[k][i[2:0]] != c) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic cltok_kind_t sym_kind(input logic [2:0] m,
                                           input logic [OFFSET_WIDTH-1:0] l);
    cltok_kind_t r;
    r = KIND_SYMBOL;
    for (int k = 0; k < 3; k++) begin
      if (m[k] && l == OFFSET_WIDTH'(KW_LEN[k])) begin
        r = KIND_KEYWORD;
      end
    end
    return r;
  endfunction

  always_comb begin
    is_blank  = (item.text_byte == CHAR_SPACE) ||
                (item.text_byte >= CHAR_TAB && item.text_byte <= CHAR_CR);
    is_letter = (item.text_byte >= 8'h61 && item.text_byte <= 8'h7a) ||
                (item.text_byte >= 8'h41 && item.text_byte <= 8'h5a);
    is_quote  = (item.text_byte == CHAR_QUOTE);
    is_nl     = (item.text_byte == CHAR_NEWLINE);
    unique case (item.text_byte)
      8'h28:   single_kind = KIND_LPAREN;
      8'h29:   single_kind = KIND_RPAREN;
      8'h7b:   single_kind = KIND_LBRACE;
      8'h7d:   single_kind = KIND_RBRACE;
      8'h7c:   single_kind = KIND_PIPE;
      default: single_kind = KIND_END;
    endcase
  end

  // Effect of the byte on the scanner, before the end of text resets it.
  always_comb begin
    mode_step  = mode;
    start_step = start;
    len_step   = len;
    match_step = match;
    taken      = 1'b0;
    close_v    = 1'b0;
    close_tok  = '{kind: KIND_STRING, start: TOK_W'(start), length: TOK_W'(len)};
    byte_v     = 1'b0;
    byte_tok   = '{kind: KIND_INVALID, start: TOK_W'(pos), length: TOK_W'(1)};
    unique case (mode)
      MODE_STRING: begin
        len_step = sat_inc(len);
        taken    = 1'b1;
        if (is_quote || is_nl) begin
          close_v          = 1'b1;
          close_tok.length = TOK_W'(len_step);
          mode_step        = MODE_IDLE;
        end
      end
      MODE_SYMBOL: begin
        if (is_letter) begin
          match_step = match_at(match, len, item.text_byte);
          len_step   = sat_inc(len);
          taken      = 1'b1;
        end else begin
          close_v        = 1'b1;
          close_tok.kind = sym_kind(match, len);
          mode_step      = MODE_IDLE;
        end
      end
      default: mode_step = MODE_IDLE;
    endcase
    if (!taken && !is_blank) begin
      if (is_quote) begin
        mode_step  = MODE_STRING;
        start_step = pos;
        len_step   = OFFSET_WIDTH'(1);
      end else if (single_kind != KIND_END) begin
        byte_v        = 1'b1;
        byte_tok.kind = single_kind;
      end else if (is_letter) begin
        mode_step  = MODE_SYMBOL;
        start_step = pos;
        len_step   = OFFSET_WIDTH'(1);
        match_step = match_at(3'b111, '0, item.text_byte);
      end else begin
        byte_v = 1'b1;
      end
    end
  end

  // Next state: the last byte of a text returns everything to reset values.
  always_comb begin
    mode_next  = mode;
    pos_next   = pos;
    start_next = start;
    len_next   = len;
    match_next = match;
    if (take) begin
      if (item.final_byte) begin
        mode_next  = MODE_IDLE;
        pos_next   = '0;
        start_next = '0;
        len_next   = '0;
        match_next = 3'b111;
      end else begin
        mode_next  = mode_step;
        pos_next   = sat_inc(pos);
        start_next = start_step;
        len_next   = len_step;
        match_next = match_step;
      end
    end
  end

  // Outputs: pack the tokens of this byte in order into one group.
  always_comb begin
    logic [1:0] n;
    n         = 2'd0;
    flush_v   = item.final_byte && (mode_step != MODE_IDLE);
    flush_tok = '{kind:   (mode_step == MODE_STRING) ? KIND_STRING
                                                     : sym_kind(match_step, len_step),
                  start:  TOK_W'(start_step),
                  length: TOK_W'(len_step)};
    end_tok   = '{kind: KIND_END, start: TOK_W'(sat_inc(pos)), length: '0};
    grp       = '0;
    if (close_v) begin
      grp.tok[n] = close_tok;
      n          = n + 2'd1;
    end
    if (byte_v) begin
      grp.tok[n] = byte_tok;
      n          = n + 2'd1;
    end else if (flush_v) begin
      grp.tok[n] = flush_tok;
      n          = n + 2'd1;
    end
    if (item.final_byte) begin
      grp.tok[n] = end_tok;
      n          = n + 2'd1;
    end
    grp.cnt   = n;
    grp_valid = take && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      pos   <= '0;
      start <= '0;
      len   <= '0;
      match <= 3'b111;
    end else begin
      mode  <= mode_next;
      pos   <= pos_next;
      start <= start_next;
      len   <= len_next;
      match <= match_next;
    end
  end

endmodule

@@ design/cltok_queue.sv @@
// Short queue of token groups between the scanner and the token output stage.
// Depends on cltok_pkg.
module cltok_queue import cltok_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  cltok_group_t wr_grp,
  output logic         full,
  input  logic         rd_en,
  output logic         rd_valid,
  output cltok_group_t rd_grp
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  cltok_group_t     slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_grp   = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/cltok_back.sv @@
// Token output stage: takes groups apart into single tokens, one per cycle when the
// output register is free or popped, and holds the oldest one there. Depends on cltok_pkg.
module cltok_back import cltok_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         grp_valid,
  input  cltok_group_t grp,
  output logic         grp_pop,
  output logic         empty,
  input  logic         pop,
  output cltok_out_t   token
);

  logic       out_valid;
  logic [1:0] idx;
  logic       load, last_in_grp;
  cltok_tok_t cur;

  assign cur         = grp.tok[idx];
  assign last_in_grp = (idx == grp.cnt - 2'd1);
  assign load        = grp_valid && (!out_valid || pop);
  assign grp_pop     = load && last_in_grp;
  assign empty       = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      token.token_kind   <= cur.kind;
      token.token_start  <= cur.start;
      token.token_length <= cur.length;
      token.run_end      <= last_in_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last_in_grp ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ design/config_language_tokenizer.sv @@
// Tokenizer for a small configuration language. One byte of text is taken per
// clock cycle whenever full is low; a byte yields zero to three tokens (a symbol
// it closes, the token it makes or finishes, and the end token after the last
// byte). Tokens leave through an output register at one per cycle while the
// receiver pops, so the sustained rate is one byte per cycle as long as bytes
// average at most one token each; the single-token output port sets that limit, and
// the group queue between scanner and output (QUEUE_DEPTH entries) absorbs bursts.
// A byte's group passes the queue before its first token is loaded into the output
// register. Depends on cltok_pkg, cltok_front, cltok_queue and cltok_back.
module config_language_tokenizer import cltok_pkg::*; #(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  cltok_in_t  text,
  output logic       empty,
  input  logic       pop,
  output cltok_out_t token
);

  logic         take;
  logic         fe_valid, q_valid, q_pop;
  cltok_group_t fe_grp, q_grp;

  assign take = push && !full;

  cltok_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (text),
    .grp_valid (fe_valid),
    .grp       (fe_grp)
  );

  cltok_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fe_valid),
    .wr_grp   (fe_grp),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_grp   (q_grp)
  );

  cltok_back u_back (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (q_valid),
    .grp       (q_grp),
    .grp_pop   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .token     (token)
  );

endmodule

@@ design/cltok_checker.sv @@
// Port-level checks for the tokenizer, attached to the top level by bind.
// Depends on cltok_pkg and config_language_tokenizer_assert.svh.
`include "config_language_tokenizer_assert.svh"

module cltok_checker import cltok_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input cltok_in_t  text,
  input logic       empty,
  input logic       pop,
  input cltok_out_t token
);

  // No item is waiting right after reset.
  `CLTOK_ASSERT_NEXT(a_empty_after_reset, rst, empty)

  // A waiting item that is not popped stays as it is.
  `CLTOK_ASSERT_NOW(a_hold_stalled, !empty && !pop, ##1 (!empty && $stable(token)))

  // The end token has no length and always closes the run of its byte.
  `CLTOK_ASSERT_NOW(a_end_token, !empty && token.token_kind == KIND_END,
                    token.token_length == '0 && token.run_end)

  // Punctuation and invalid bytes are tokens of exactly one byte.
  `CLTOK_ASSERT_NOW(a_single_len, !empty && (token.token_kind == KIND_LPAREN ||
                    token.token_kind == KIND_RPAREN || token.token_kind == KIND_LBRACE ||
                    token.token_kind == KIND_RBRACE || token.token_kind == KIND_PIPE ||
                    token.token_kind == KIND_INVALID), token.token_length == TOK_W'(1))

endmodule

bind config_language_tokenizer cltok_checker u_checker (.*);

@@ verif/config_language_tokenizer_checker.sv @@
// Token checker for the configuration language tokenizer: watches both its ports,
// predicts the tokens of every accepted byte and compares them in order.
// Depends on cltok_pkg for the item types, token kinds and scan modes.
`timescale 1ns / 1ps

module config_language_tokenizer_checker import cltok_pkg::*; #(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  cltok_in_t  text,
  input  logic       empty,
  input  logic       pop,
  input  cltok_out_t token,
  output int         errors,
  output int         pending
);

  localparam logic [31:0] OFFSET_MAX = 32'((64'd1 << OFFSET_WIDTH) - 64'd1);
  localparam logic [7:0]  CH_QUOTE   = 8'h22;
  localparam logic [7:0]  CH_NEWLINE = 8'h0a;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  CH_LPAREN  = 8'h28;
  localparam logic [7:0]  CH_RPAREN  = 8'h29;
  localparam logic [7:0]  CH_LBRACE  = 8'h7b;
  localparam logic [7:0]  CH_RBRACE  = 8'h7d;
  localparam logic [7:0]  CH_PIPE    = 8'h7c;

  string       kw_words [3];
  cltok_mode_t mode;
  logic [31:0] pos;
  logic [31:0] tok_start;
  logic [31:0] tok_len;
  logic [2:0]  kw_live;
  cltok_out_t  expected_tokens [$];

  initial begin
    kw_words[0] = "setup";
    kw_words[1] = "provides";
    kw_words[2] = "command";
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v >= OFFSET_MAX) ? OFFSET_MAX : v + 32'd1;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  task automatic clear_state();
    mode      = MODE_IDLE;
    pos       = '0;
    tok_start = '0;
    tok_len   = '0;
    kw_live   = 3'b111;
  endtask

  task automatic add_token(input cltok_kind_t kind, input logic [31:0] start,
                           input logic [31:0] len);
    cltok_out_t t;
    t.token_kind   = kind;
    t.token_start  = start[TOK_W-1:0];
    t.token_length = len[TOK_W-1:0];
    t.run_end      = 1'b0;
    expected_tokens.push_back(t);
  endtask

  // Drops every keyword whose letter at the current word position differs from c.
  task automatic narrow_keywords(input logic [7:0] c);
    for (int k = 0; k < 3; k++) begin
      if (tok_len >= kw_words[k].len() || kw_words[k][tok_len] != c) kw_live[k] = 1'b0;
    end
  endtask

  function automatic cltok_kind_t word_kind();
    for (int k = 0; k < 3; k++) begin
      if (kw_live[k] && kw_words[k].len() == tok_len) return KIND_KEYWORD;
    end
    return KIND_SYMBOL;
  endfunction

  task automatic scan_byte(input logic [7:0] c, input logic last);
    logic [31:0] at;
    int          before_cnt;
    bit          consumed;
    at         = pos;
    before_cnt = expected_tokens.size();
    consumed   = 1'b0;
    if (mode == MODE_STRING) begin
      tok_len = sat_inc(tok_len);
      if (c == CH_QUOTE || c == CH_NEWLINE) begin
        add_token(KIND_STRING, tok_start, tok_len);
        mode = MODE_IDLE;
      end
      consumed = 1'b1;
    end else if (mode == MODE_SYMBOL) begin
      if (is_letter(c)) begin
        narrow_keywords(c);
        tok_len  = sat_inc(tok_len);
        consumed = 1'b1;
      end else begin
        add_token(word_kind(), tok_start, tok_len);
        mode = MODE_IDLE;
      end
    end else begin
      mode = MODE_IDLE;
    end
    if (!consumed) begin
      if (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0d)) begin
        // whitespace only advances the offset
      end else if (c == CH_QUOTE) begin
        mode      = MODE_STRING;
        tok_start = at;
        tok_len   = 32'd1;
      end else if (is_letter(c)) begin
        mode      = MODE_SYMBOL;
        tok_start = at;
        tok_len   = '0;
        kw_live   = 3'b111;
        narrow_keywords(c);
        tok_len   = 32'd1;
      end else begin
        case (c)
          CH_LPAREN: add_token(KIND_LPAREN, at, 32'd1);
          CH_RPAREN: add_token(KIND_RPAREN, at, 32'd1);
          CH_LBRACE: add_token(KIND_LBRACE, at, 32'd1);
          CH_RBRACE: add_token(KIND_RBRACE, at, 32'd1);
          CH_PIPE:   add_token(KIND_PIPE, at, 32'd1);
          default:   add_token(KIND_INVALID, at, 32'd1);
        endcase
      end
    end
    pos = sat_inc(at);
    if (last) begin
      if (mode == MODE_STRING) add_token(KIND_STRING, tok_start, tok_len);
      else if (mode == MODE_SYMBOL) add_token(word_kind(), tok_start, tok_len);
      add_token(KIND_END, pos, 32'd0);
      clear_state();
    end
    if (expected_tokens.size() > before_cnt) expected_tokens[$].run_end = 1'b1;
  endtask

  always @(posedge clk) begin
    cltok_out_t want;
    if (rst) begin
      clear_state();
      expected_tokens.delete();
      errors = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_tokens.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("%0t: token with no byte behind it: kind %0d start %0d length %0d end %0b",
                     $time, token.token_kind, token.token_start, token.token_length,
                     token.run_end);
        end else begin
          want = expected_tokens.pop_front();
          if (token.token_kind !== want.token_kind || token.token_start !== want.token_start ||
              token.token_length !== want.token_length || token.run_end !== want.run_end) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("%0t: token mismatch: expected kind %0d start %0d length %0d end %0b, %s",
                       $time, want.token_kind, want.token_start, want.token_length,
                       want.run_end,
                       $sformatf("got kind %0d start %0d length %0d end %0b",
                                 token.token_kind, token.token_start, token.token_length,
                                 token.run_end));
          end
        end
      end
      if (push && !full) scan_byte(text.text_byte, text.final_byte);
    end
    pending <= expected_tokens.size();
  end

endmodule

@@ verif/config_language_tokenizer_tb.sv @@
// Top of the tokenizer testbench: clock, reset, byte stimulus and token draining,
// plus the final verdict. Depends on cltok_pkg, the tokenizer and its checker.
`timescale 1ns / 1ps

module config_language_tokenizer_tb;
  import cltok_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_BYTES = 250;
  localparam int CALM_TAIL    = 60;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  cltok_in_t  text;
  logic       empty;
  logic       pop;
  cltok_out_t token;

  int         mismatch_count;
  int         tokens_waiting;
  int         cycle_count = 0;
  bit         tx_idle_on;
  bit         rx_idle_on;
  bit         hold_request;
  logic [7:0] script [$];

  config_language_tokenizer i_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .text  (text),
    .empty (empty),
    .pop   (pop),
    .token (token)
  );

  config_language_tokenizer_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .text    (text),
    .empty   (empty),
    .pop     (pop),
    .token   (token),
    .errors  (mismatch_count),
    .pending (tokens_waiting)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Token side: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        stall_left   = 300;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] rand_letter();
    logic [7:0] r;
    r = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? 8'h61 + r : 8'h41 + r;
  endfunction

  function automatic logic [7:0] rand_blank();
    return $urandom_range(0, 3) == 0 ? 8'h20 : 8'($urandom_range(9, 13));
  endfunction

  task automatic add_word(input string s);
    for (int i = 0; i < s.len(); i++) script.push_back(s[i]);
  endtask

  // Called right after a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    push <= 1'b1;
    text.text_byte  <= b;
    text.final_byte <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_script();
    for (int i = 0; i < script.size(); i++) send_byte(script[i], i == script.size() - 1);
    script.delete();
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (tokens_waiting != 0);
  endtask

  // Mostly well-formed pieces of the language, with some noise in between.
  task automatic build_random_text();
    int         pieces;
    int         len;
    int         cut;
    logic [7:0] b;
    string      word;
    string      punct;
    punct  = "(){}|";
    pieces = $urandom_range(1, 8);
    repeat (pieces) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          case ($urandom_range(0, 2))
            0: word = "setup";
            1: word = "provides";
            default: word = "command";
          endcase
          len = word.len();
          case ($urandom_range(0, 4))
            0: begin
              cut = $urandom_range(1, len - 1);
              for (int i = 0; i < cut; i++) script.push_back(word[i]);
            end
            1: begin
              add_word(word);
              repeat ($urandom_range(1, 2)) script.push_back(rand_letter());
            end
            2: begin
              cut = $urandom_range(0, len - 1);
              for (int i = 0; i < len; i++)
                script.push_back(i == cut ? rand_letter() : word[i]);
            end
            default: add_word(word);
          endcase
        end
        3, 4: repeat ($urandom_range(1, 10)) script.push_back(rand_letter());
        5, 6: repeat ($urandom_range(1, 3)) script.push_back(punct[$urandom_range(0, 4)]);
        7: begin
          add_word("\"");
          repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            if (b == 8'h22 || b == 8'h0a) b = rand_letter();
            script.push_back(b);
          end
          // A string left open swallows whatever follows until a quote or newline.
          case ($urandom_range(0, 3))
            0, 1: add_word("\"");
            2: script.push_back(8'h0a);
            default: ;
          endcase
        end
        8: repeat ($urandom_range(1, 3)) script.push_back(rand_blank());
        default: repeat ($urandom_range(1, 2)) script.push_back(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 2) != 0) script.push_back(rand_blank());
    end
  endtask

  initial begin
    int random_bytes;
    rst          = 1'b1;
    push         = 1'b0;
    text         = '0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_request = 1'b0;
    random_bytes = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A keyword closed by a paren on the last byte gives three tokens at once.
    add_word("setup(");
    send_script();
    // Every single-byte token but the left paren, every blank, and bytes outside the letters.
    add_word(") {");
    script.push_back(8'h09);
    add_word("}");
    script.push_back(8'h0a);
    add_word("|");
    script.push_back(8'h0b);
    script.push_back(8'h00);
    script.push_back(8'h0c);
    script.push_back(8'hff);
    script.push_back(8'h0d);
    script.push_back(8'h80);
    script.push_back(8'h7f);
    send_script();
    add_word("\"a");
    send_script();
    script.push_back(8'h22);
    script.push_back(8'h0a);
    send_script();
    add_word("ab");
    send_script();
    add_word("\"");
    send_script();
    wait_drained();

    // The receiver holds off while parens keep coming, so the block backs up.
    hold_request = 1'b1;
    repeat (40) add_word("(");
    add_word("}");
    send_script();
    wait_drained();

    while (random_bytes < RANDOM_BYTES) begin
      build_random_text();
      random_bytes += script.size();
      if (random_bytes >= RANDOM_BYTES - CALM_TAIL) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      send_script();
      if ($urandom_range(0, 15) == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && tokens_waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/cltok_pkg.sv
design/cltok_front.sv
design/cltok_queue.sv
design/cltok_back.sv
design/config_language_tokenizer.sv
design/cltok_checker.sv
verif/config_language_tokenizer_checker.sv
verif/config_language_tokenizer_tb.sv
